// ===== rtl/bm25_document_scorer_defines.svh =====
// Assertion macros for the BM25 scorer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BM25_DOCUMENT_SCORER_DEFINES_SVH
`define BM25_DOCUMENT_SCORER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BM25_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);
`define BM25_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error(msg);
`else
`define BM25_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define BM25_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// ===== rtl/bm25_pkg.sv =====
// Shared constants, types and helpers for the BM25 scorer.
// No dependencies; used by the interfaces, the divider and the top level.
`timescale 1ns / 1ps

package bm25_pkg;

  localparam int COUNT_BITS    = 24;
  localparam int FREQ_BITS     = 16;
  localparam int SCORE_BITS    = 32;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = COUNT_BITS;

  // log unit
  localparam int ARG_BITS  = COUNT_BITS + 1;  // 2x+1 of a count
  localparam int TOP_BITS  = 5;
  localparam int LOG_FRAC  = 24;
  localparam int MANT_BITS = 31;              // Q1.30 mantissa
  localparam int LG_BITS   = 29;              // log2 / ln in Q.24
  localparam int SQ_STEPS  = LOG_FRAC;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // divider
  localparam int DIV_X_BITS   = 48;
  localparam int DIV_Q_BITS   = 25;
  localparam int DIV_CNT_BITS = 5;
  localparam int TF_STEPS     = 18;
  localparam int QTF_STEPS    = 25;
  localparam int TFQ_BITS     = 18;
  localparam int TQ_BITS      = 27;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NUM_DOCS       = 1'b0,
    REG_AVG_DOC_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LN_NORM,
    ST_LN_SQ,
    ST_LN_MUL,
    ST_TF_MUL,
    ST_DIV_TF,
    ST_DIV_QTF,
    ST_TQ_MUL,
    ST_TERM_MUL,
    ST_ACC
  } state_t;

  typedef struct packed {
    logic                    start;
    logic [DIV_CNT_BITS-1:0] steps;
    logic [DIV_X_BITS-1:0]   x;
    logic [DIV_X_BITS-1:0]   d;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIV_Q_BITS-1:0] q;
  } div_sts_t;

  // index of the leading one, zero for zero
  function automatic logic [TOP_BITS-1:0] msb_index(input logic [ARG_BITS-1:0] v);
    logic [TOP_BITS-1:0] idx;
    idx = '0;
    for (int i = 0; i < ARG_BITS; i++) begin
      if (v[i]) idx = TOP_BITS'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/bm25_if.sv =====
// Valid/ready channels for the BM25 scorer: term words in, score words out.
// Depends on bm25_pkg for field widths.
`timescale 1ns / 1ps

interface bm25_term_if import bm25_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [FREQ_BITS-1:0]  term_count;
  logic [FREQ_BITS-1:0]  query_term_count;
  logic [COUNT_BITS-1:0] doc_freq;
  logic [COUNT_BITS-1:0] doc_length;
  logic                  last_term;

  modport source (output valid, term_count, query_term_count, doc_freq, doc_length,
                  last_term, input ready);
  modport sink   (input valid, term_count, query_term_count, doc_freq, doc_length,
                  last_term, output ready);
endinterface

interface bm25_score_if import bm25_pkg::*; ;
  logic                         valid;
  logic                         ready;
  logic signed [SCORE_BITS-1:0] score;
  logic                         saturated;

  modport source (output valid, score, saturated, input ready);
  modport sink   (input valid, score, saturated, output ready);
endinterface

// ===== rtl/bm25_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bm25_pkg (div_req_t, div_sts_t).
`timescale 1ns / 1ps
`include "bm25_document_scorer_defines.svh"

module bm25_div import bm25_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_sts_t sts
);

  logic [DIV_X_BITS-1:0]   x;
  logic [DIV_X_BITS-1:0]   d;
  logic [DIV_Q_BITS-1:0]   q;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic                    done;

  logic [DIV_X_BITS-1:0] x2;
  logic                  ge;

  // x < d always holds, so the doubled remainder fits
  assign x2 = {x[DIV_X_BITS-2:0], 1'b0};
  assign ge = (x2 >= d);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        x    <= req.x;
        d    <= req.d;
        q    <= '0;
        cnt  <= req.steps - DIV_CNT_BITS'(1);
        busy <= 1'b1;
      end else if (busy) begin
        x   <= ge ? (x2 - d) : x2;
        q   <= {q[DIV_Q_BITS-2:0], ge};
        cnt <= cnt - DIV_CNT_BITS'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign sts.q    = q;

  `BM25_ASSERT(a_start_idle, clk, rst, req.start |-> !busy, "divider started while busy")
  `BM25_ASSERT(a_last_done, clk, rst, (busy && cnt == '0 && !req.start) |=> done, "no done after last step")
  `BM25_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> (!busy && !done), "divider active after reset")

endmodule

// ===== rtl/bm25_document_scorer.sv =====
// BM25 term scorer: 48 squaring steps of the shared multiplier (two logs) and
// 43 divider steps take up most of the time from an accepted term word to ready again.
// One word at a time; a score word enters the output register with its last term
// word's accumulate step and may wait there while the next term is worked on.
// Synchronous active-high reset: idle, score and sticky flag cleared,
// num_docs and avg_doc_length back to 1.
`timescale 1ns / 1ps
`include "bm25_document_scorer_defines.svh"

module bm25_document_scorer import bm25_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  bm25_term_if.sink                term_in,
  bm25_score_if.source             score_out
);

  // configuration
  logic [COUNT_BITS-1:0] num_docs;
  logic [COUNT_BITS-1:0] avg_doc_length;

  // accumulator
  logic signed [SCORE_BITS-1:0] score_sum;
  logic                         sat_seen;

  // latched term word
  logic [FREQ_BITS-1:0]  tf;
  logic [FREQ_BITS-1:0]  qf;
  logic [COUNT_BITS-1:0] dl;
  logic [COUNT_BITS-1:0] avg;
  logic                  last;
  logic [ARG_BITS-1:0]   arg_a;
  logic [ARG_BITS-1:0]   arg_b;

  // log unit state
  logic                    ln_second;
  logic [MANT_BITS-1:0]    y;
  logic [LG_BITS-1:0]      lg;
  logic [TOP_BITS-1:0]     sq_cnt;
  logic [LG_BITS-1:0]      la;
  logic [LG_BITS-1:0]      lb;

  // products
  logic                    idf_neg;
  logic [LG_BITS-1:0]      idf_mag;
  logic [TFQ_BITS-1:0]     tfq;
  logic [TQ_BITS-1:0]      tq;
  logic [SCORE_BITS-1:0]   mag;

  // output register
  logic                         out_valid;
  logic signed [SCORE_BITS-1:0] out_score;
  logic                         out_sat;

  state_t state, state_next;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  div_req_t div_req;
  div_sts_t div_sts;

  logic accept;
  logic out_free;

  // front-end clamps
  logic [COUNT_BITS-1:0] n_eff;
  logic [COUNT_BITS-1:0] avg_eff;
  logic [COUNT_BITS-1:0] df_eff;

  // log normalise
  logic [ARG_BITS-1:0]  ln_arg;
  logic [TOP_BITS-1:0]  ln_top;
  logic [MANT_BITS-1:0] ln_mant;
  logic [31:0]          sq;

  // TF operands
  logic [39:0] avg_tf;
  logic [44:0] tf_num;
  logic [43:0] tf_den;
  logic [25:0] qtf_num;
  logic [16:0] qtf_den;

  // accumulate
  logic signed [SCORE_BITS+1:0] acc_sum;
  logic signed [SCORE_BITS-1:0] acc_sat;
  logic                         acc_hit;

  bm25_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .sts (div_sts)
  );

  assign accept   = term_in.valid && term_in.ready;
  assign out_free = !out_valid || score_out.ready;

  assign n_eff   = (num_docs == '0) ? COUNT_BITS'(1) : num_docs;
  assign avg_eff = (avg_doc_length == '0) ? COUNT_BITS'(1) : avg_doc_length;
  assign df_eff  = (term_in.doc_freq > n_eff) ? n_eff : term_in.doc_freq;

  // mantissa in [1,2) as Q1.30, exponent into the integer part of log2
  assign ln_arg  = ln_second ? arg_b : arg_a;
  assign ln_top  = msb_index(ln_arg);
  assign ln_mant = MANT_BITS'({{(MANT_BITS-ARG_BITS){1'b0}}, ln_arg} << (5'd30 - ln_top));
  assign sq      = mul_p[61:30];

  // TF = 20*avg*tf / (3*avg + 9*dl + 8*avg*tf), QTF = 501*qtf / (500 + qtf)
  assign avg_tf  = mul_p[39:0];
  assign tf_num  = {1'b0, avg_tf, 4'b0} + {3'b0, avg_tf, 2'b0};
  assign tf_den  = 44'({avg, 1'b0}) + 44'(avg) + 44'({dl, 3'b0}) + 44'(dl)
                 + 44'({avg_tf, 3'b0});
  assign qtf_num = 26'(qf) * 26'd501;
  assign qtf_den = 17'(qf) + 17'd500;

  assign acc_sum = idf_neg ? (34'(score_sum) - $signed({2'b0, mag}))
                           : (34'(score_sum) + $signed({2'b0, mag}));

  always_comb begin
    acc_hit = 1'b0;
    acc_sat = acc_sum[SCORE_BITS-1:0];
    if (acc_sum > 34'sh0_7FFF_FFFF) begin
      acc_sat = {1'b0, {(SCORE_BITS-1){1'b1}}};
      acc_hit = 1'b1;
    end else if (acc_sum < -34'sh0_8000_0000) begin
      acc_sat = {1'b1, {(SCORE_BITS-1){1'b0}}};
      acc_hit = 1'b1;
    end
  end

  assign mul_p = mul_a * mul_b;

  // sequencer: next state, multiplier operands, divider requests
  always_comb begin
    state_next    = state;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;
    term_in.ready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (term_in.valid) state_next = ST_LN_NORM;
      end
      ST_LN_NORM: begin
        state_next = ST_LN_SQ;
      end
      ST_LN_SQ: begin
        mul_a = {1'b0, y};
        mul_b = {1'b0, y};
        if (sq_cnt == '0) state_next = ST_LN_MUL;
      end
      ST_LN_MUL: begin
        mul_a = 32'(lg);
        mul_b = LN2_Q32;
        state_next = ln_second ? ST_TF_MUL : ST_LN_NORM;
      end
      ST_TF_MUL: begin
        mul_a         = 32'(avg);
        mul_b         = 32'(tf);
        div_req.start = 1'b1;
        div_req.steps = DIV_CNT_BITS'(TF_STEPS);
        div_req.x     = DIV_X_BITS'(tf_num);
        div_req.d     = DIV_X_BITS'({tf_den, 2'b0});
        state_next    = ST_DIV_TF;
      end
      ST_DIV_TF: begin
        if (div_sts.done) begin
          div_req.start = 1'b1;
          div_req.steps = DIV_CNT_BITS'(QTF_STEPS);
          div_req.x     = DIV_X_BITS'(qtf_num);
          div_req.d     = DIV_X_BITS'({qtf_den, 9'b0});
          state_next    = ST_DIV_QTF;
        end
      end
      ST_DIV_QTF: begin
        if (div_sts.done) state_next = ST_TQ_MUL;
      end
      ST_TQ_MUL: begin
        mul_a = 32'(tfq);
        mul_b = 32'(div_sts.q);
        state_next = ST_TERM_MUL;
      end
      ST_TERM_MUL: begin
        mul_a = 32'(idf_mag);
        mul_b = 32'(tq);
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (!last || out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // config, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_docs       <= COUNT_BITS'(1);
      avg_doc_length <= COUNT_BITS'(1);
      score_sum      <= '0;
      sat_seen       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_NUM_DOCS)       num_docs       <= cfg_wdata;
        if (cfg_index == REG_AVG_DOC_LENGTH) avg_doc_length <= cfg_wdata;
      end
      // a new score word may replace one leaving on the same edge
      if (state == ST_ACC && last && out_free) out_valid <= 1'b1;
      else if (score_out.ready)                out_valid <= 1'b0;
      if (state == ST_ACC) begin
        if (!last) begin
          score_sum <= acc_sat;
          sat_seen  <= sat_seen | acc_hit;
        end else if (out_free) begin
          out_score <= acc_sat;
          out_sat   <= sat_seen | acc_hit;
          score_sum <= '0;
          sat_seen  <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          tf        <= term_in.term_count;
          qf        <= term_in.query_term_count;
          dl        <= term_in.doc_length;
          last      <= term_in.last_term;
          avg       <= avg_eff;
          arg_a     <= {n_eff - df_eff, 1'b1};
          arg_b     <= {df_eff, 1'b1};
          ln_second <= 1'b0;
        end
      end
      ST_LN_NORM: begin
        y      <= ln_mant;
        lg     <= {ln_top, {LOG_FRAC{1'b0}}};
        sq_cnt <= TOP_BITS'(SQ_STEPS - 1);
      end
      ST_LN_SQ: begin
        // square truncated to 30 fraction bits; a carry past 2 gives a log bit
        if (sq[31]) begin
          y          <= sq[31:1];
          lg[sq_cnt] <= 1'b1;
        end else begin
          y <= sq[30:0];
        end
        sq_cnt <= sq_cnt - TOP_BITS'(1);
      end
      ST_LN_MUL: begin
        if (ln_second) lb <= mul_p[60:32];
        else           la <= mul_p[60:32];
        ln_second <= 1'b1;
      end
      ST_TF_MUL: begin
        // IDF = ln(2(N-df)+1) - ln(2df+1), kept as sign and magnitude
        idf_neg <= (lb > la);
        idf_mag <= (lb > la) ? (lb - la) : (la - lb);
      end
      ST_DIV_TF: begin
        if (div_sts.done) tfq <= div_sts.q[TFQ_BITS-1:0];
      end
      ST_TQ_MUL: begin
        tq <= mul_p[42:16];
      end
      ST_TERM_MUL: begin
        mag <= mul_p[55:24];
      end
      default: begin
      end
    endcase
  end

  assign score_out.valid     = out_valid;
  assign score_out.score     = out_score;
  assign score_out.saturated = out_sat;

  `BM25_ASSERT(a_busy_after_accept, clk, rst, accept |=> !term_in.ready, "took a word while busy")
  `BM25_ASSERT(a_out_from_acc, clk, rst, $rose(out_valid) |-> $past(state == ST_ACC), "score word not from accumulate")
  `BM25_ASSERT(a_sq_to_mul, clk, rst, (state == ST_LN_SQ && sq_cnt == '0) |=> state == ST_LN_MUL, "log squaring overran")
  `BM25_ASSERT(a_div_wait, clk, rst, (state == ST_DIV_QTF) |-> (div_sts.busy || div_sts.done), "waiting on idle divider")

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for bm25_document_scorer: random and directed term words
// go in, score words are compared with a local fixed-point BM25 predictor.
// Depends on bm25_pkg and the channel interfaces in rtl/bm25_if.sv.
`timescale 1ns / 1ps

module tb_top;
  import bm25_pkg::*;

  typedef struct {
    logic signed [SCORE_BITS-1:0] score;
    logic                         saturated;
  } score_word_t;

  int unsigned n_errors = 0;

  // one line per mismatch, and a count for the final verdict
  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Running BM25 prediction: copy of the block's registers, accumulator
  // and sticky flag, plus the score words still owed by the block.
  class doc_score_tracker;
    longint unsigned num_docs = 1;
    longint unsigned avg_len  = 1;
    longint          score_acc = 0;
    bit              sat_flag  = 0;
    score_word_t     owed[$];

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_NUM_DOCS:       num_docs = 64'(val);
        REG_AVG_DOC_LENGTH: avg_len  = 64'(val);
        default: ;
      endcase
    endfunction

    // ln(v) in Q.24: log2 by repeated squaring of a Q1.30 mantissa, then * ln2
    function longint unsigned ln_q24(longint unsigned v);
      int unsigned     top;
      longint unsigned y, lg;
      top = 0;
      if (v == 0) v = 1;
      while (top < 63 && (v >> (top + 1)) != 0) top++;
      y  = (top <= 30) ? (v << (30 - top)) : (v >> (top - 30));
      lg = longint'(top) << LOG_FRAC;
      for (int i = LOG_FRAC - 1; i >= 0; i--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          lg |= 64'd1 << i;
          y >>= 1;
        end
      end
      return (lg * 64'd2977044472) >> 32;
    endfunction

    function void note_term(logic [FREQ_BITS-1:0] tf, logic [FREQ_BITS-1:0] qf,
                            logic [COUNT_BITS-1:0] df_in, logic [COUNT_BITS-1:0] dl,
                            logic last);
      longint unsigned n, a, df, la, lb, idf, num, den, tfq, qtf, tq, mag;
      bit              neg;
      longint          s;
      score_word_t     w;
      n  = num_docs ? num_docs : 1;
      a  = avg_len ? avg_len : 1;
      df = 64'(df_in);
      if (df > n) df = n;  // df clamped to the collection size
      la  = ln_q24(2 * (n - df) + 1);
      lb  = ln_q24(2 * df + 1);
      neg = lb > la;
      idf = neg ? lb - la : la - lb;
      num = 20 * a * tf;
      den = 3 * a + 9 * longint'(dl) + 8 * a * tf;
      tfq = den ? (num << 16) / den : 0;
      qtf = ((501 * longint'(qf)) << 16) / (500 + longint'(qf));
      tq  = (tfq * qtf) >> 16;
      mag = (idf * tq) >> LOG_FRAC;
      if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
      s = neg ? score_acc - longint'(mag) : score_acc + longint'(mag);
      if (s > 64'sd2147483647) begin
        s = 64'sd2147483647;
        sat_flag = 1;
      end else if (s < -64'sd2147483648) begin
        s = -64'sd2147483648;
        sat_flag = 1;
      end
      score_acc = s;
      if (last) begin
        w.score     = score_acc[31:0];
        w.saturated = sat_flag;
        owed.insert(owed.size(), w);
        score_acc = 0;
        sat_flag  = 0;
      end
    endfunction

    task check_score(logic signed [SCORE_BITS-1:0] score, logic sat);
      score_word_t w;
      if (owed.size() == 0) begin
        report($sformatf("unexpected score word %0d sat %0b", score, sat));
        return;
      end
      w = owed.pop_front();
      if (score !== w.score)
        report($sformatf("score %0d, want %0d", score, w.score));
      if (sat !== w.saturated)
        report($sformatf("saturated %0b, want %0b", sat, w.saturated));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic                     cfg_wr_en = 0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  bm25_term_if  term_ch ();
  bm25_score_if score_ch ();

  bm25_document_scorer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .term_in   (term_ch.sink),
    .score_out (score_ch.source)
  );

  always #5 clk = ~clk;

  doc_score_tracker tracker = new();
  int unsigned tx_idle_pct = 0;  // chance, per word, of a gap before it
  int unsigned rx_idle_pct = 0;  // chance, per cycle, of ready low
  int unsigned quiet_cycles = 0;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 150;  // outlasts one term in flight

  initial begin
    term_ch.valid            = 0;
    term_ch.term_count       = '0;
    term_ch.query_term_count = '0;
    term_ch.doc_freq         = '0;
    term_ch.doc_length       = '0;
    term_ch.last_term        = 0;
    score_ch.ready           = 0;
  end

  // input monitor: every accepted term word updates the prediction
  always @(posedge clk) begin
    if (!rst && term_ch.valid && term_ch.ready)
      tracker.note_term(term_ch.term_count, term_ch.query_term_count,
                        term_ch.doc_freq, term_ch.doc_length, term_ch.last_term);
  end

  // score sink with random back-pressure
  always @(posedge clk) begin
    if (!rst && score_ch.valid && score_ch.ready)
      tracker.check_score(score_ch.score, score_ch.saturated);
    score_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (term_ch.valid && term_ch.ready) || (score_ch.valid && score_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // both registers, back to back; only called with the block idle
  task automatic write_regs(input logic [CFG_DATA_BITS-1:0] n_docs,
                            input logic [CFG_DATA_BITS-1:0] avg);
    cfg_wr_en <= 1;
    cfg_index <= REG_NUM_DOCS;
    cfg_wdata <= n_docs;
    tracker.set_reg(REG_NUM_DOCS, n_docs);
    @(posedge clk);
    cfg_index <= REG_AVG_DOC_LENGTH;
    cfg_wdata <= avg;
    tracker.set_reg(REG_AVG_DOC_LENGTH, avg);
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  // valid stays high across words unless a gap is drawn
  task automatic send_term(input logic [FREQ_BITS-1:0] tf, input logic [FREQ_BITS-1:0] qf,
                           input logic [COUNT_BITS-1:0] df, input logic [COUNT_BITS-1:0] dl,
                           input logic last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct && gap < 20) gap++;
    if (gap != 0) begin
      term_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    term_ch.valid            <= 1;
    term_ch.term_count       <= tf;
    term_ch.query_term_count <= qf;
    term_ch.doc_freq         <= df;
    term_ch.doc_length       <= dl;
    term_ch.last_term        <= last;
    do @(posedge clk); while (!term_ch.ready);
  endtask

  // wait for owed scores, then for any unflagged term still in flight;
  // one edge first so the monitor has noted the last word
  task automatic drain();
    term_ch.valid <= 0;
    @(posedge clk);
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly small counts, sometimes full-range ones to hit every bit
  function automatic logic [FREQ_BITS-1:0] rand_count();
    if ($urandom_range(0, 9) == 0) return FREQ_BITS'($urandom_range(0, 65535));
    return FREQ_BITS'($urandom_range(0, 40));
  endfunction

  // one document: a well-formed run of terms ending with the flagged one
  task automatic send_doc();
    int unsigned n_terms;
    longint unsigned n;
    logic [COUNT_BITS-1:0] df, dl;
    n_terms = $urandom_range(1, 7);
    n = tracker.num_docs ? tracker.num_docs : 1;
    for (int t = 0; t < n_terms; t++) begin
      case ($urandom_range(0, 3))
        0:       df = COUNT_BITS'($urandom_range(0, 16777215));
        1:       df = COUNT_BITS'(n - (n >> 3) + $urandom_range(0, n >> 2));  // near or above N
        default: df = COUNT_BITS'($urandom_range(0, (n > 64) ? n / 16 : n));
      endcase
      if ($urandom_range(0, 4) == 0) dl = COUNT_BITS'($urandom_range(0, 16777215));
      else dl = COUNT_BITS'($urandom_range(0, 3 * (tracker.avg_len + 1)));
      send_term(rand_count(), rand_count(), df, dl, t == n_terms - 1);
    end
  endtask

  initial begin
    int unsigned sent;
    logic [CFG_DATA_BITS-1:0] n_docs, avg;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset registers first, then a typical collection
    send_term(3, 1, 0, 5, 1);
    drain();
    write_regs(1000, 100);
    send_term(0, 7, 10, 100, 1);                   // zero tf
    send_term(7, 0, 10, 100, 1);                   // zero qtf
    send_term(65535, 65535, 0, 0, 1);              // max counts, df zero
    send_term(65535, 65535, 16777215, 16777215, 1);// df clamped to N
    send_term(5, 2, 1000, 100, 1);                 // df equal to N
    send_term(5, 2, 500, 100, 1);                  // df half N, IDF near zero
    send_term(5, 2, 900, 100, 0);                  // negative IDF, not last
    send_term(4, 1, 3, 16777215, 1);               // huge document
    for (int i = 0; i < 6; i++)                    // drive into positive saturation
      send_term(65535, 65535, 0, 0, i == 5);
    for (int i = 0; i < 6; i++)                    // and into negative saturation
      send_term(65535, 65535, 999, 0, i == 5);
    send_term(2, 1, 1, 50, 1);                     // sticky flag cleared after last
    drain();
    write_regs(0, 0);                              // both read as one
    send_term(9, 3, 0, 2, 0);
    send_term(9, 3, 5, 2, 1);
    drain();
    write_regs(16777215, 16777215);
    send_term(65535, 65535, 1, 16777215, 1);
    send_term(1, 1, 16777214, 0, 1);
    drain();

    // random phases: three idle modes, each under two register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin tx_idle_pct = 24; rx_idle_pct = 63; end
        1: begin tx_idle_pct = 63; rx_idle_pct = 24; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (ph)
        0: begin n_docs = 16777215; avg = 1; end
        1: begin n_docs = 1; avg = 16777215; end
        default: begin
          n_docs = CFG_DATA_BITS'($urandom_range(1, 1 << $urandom_range(1, 23)));
          avg    = CFG_DATA_BITS'($urandom_range(1, 1 << $urandom_range(1, 12)));
        end
      endcase
      write_regs(n_docs, avg);
      sent = 0;
      while (sent < 220) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: a lone word of anything, flagged or not
          send_term(FREQ_BITS'($urandom_range(0, 65535)), FREQ_BITS'($urandom_range(0, 65535)),
                    COUNT_BITS'($urandom_range(0, 16777215)),
                    COUNT_BITS'($urandom_range(0, 16777215)),
                    1'($urandom_range(0, 1)));
          sent++;
        end else begin
          send_doc();
          sent += 4;
        end
      end
      send_term(1, 1, 1, 1, 1);  // close any open document
      drain();
    end

    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
